/* rtl/grid_bfs_shortest_path_defines.svh */
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path assertion macros
// concurrent check helpers shared by the maze search block
// ----------------------------------------------------------------------------
`ifndef GRID_BFS_SHORTEST_PATH_DEFINES_SVH
`define GRID_BFS_SHORTEST_PATH_DEFINES_SVH

// same-cycle implication
`define GBSP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBSP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/gbsp_pkg.sv */
// ----------------------------------------------------------------------------
// gbsp_pkg
// shared types and constants for the grid breadth-first search block
// ----------------------------------------------------------------------------
package gbsp_pkg;

   localparam int CFG_W        = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_ADDR_LSB = 2;
   localparam int REG_SEL_W    = CSR_ADDR_W - CSR_ADDR_LSB;
   localparam int CNT_W        = 15;

   localparam int DEF_MAX_ROWS = 128;
   localparam int DEF_MAX_COLS = 128;

   localparam logic [CFG_W-1:0] RESET_ROWS = 8'd128;
   localparam logic [CFG_W-1:0] RESET_COLS = 8'd128;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [REG_SEL_W-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [REG_SEL_W-1:0] REG_GRID_COLS = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
   } gbsp_size_type;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_LEFT,
      DIR_DOWN,
      DIR_RIGHT
   } gbsp_dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_START,
      ST_POP,
      ST_FETCH,
      ST_PROBE,
      ST_LAST
   } gbsp_state_type;

endpackage

/* rtl/gbsp_ram.sv */
// ----------------------------------------------------------------------------
// gbsp_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gbsp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gbsp_nbr_unit.sv */
// ----------------------------------------------------------------------------
// gbsp_nbr_unit
// neighbor address unit: one adder steps the cell index by -cols, -1, +cols
// or +1, with the matching row/column update and grid bounds check
// ----------------------------------------------------------------------------
module gbsp_nbr_unit import gbsp_pkg::*; #(
   parameter int IDX_W = 14,
   parameter int R_W   = 7,
   parameter int C_W   = 7
) (
   input  gbsp_dir_type     dir,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic [R_W-1:0]   cell_r,
   input  logic [C_W-1:0]   cell_c,
   input  gbsp_size_type    size,
   output logic [IDX_W-1:0] nbr_idx,
   output logic [R_W-1:0]   nbr_r,
   output logic [C_W-1:0]   nbr_c,
   output logic             in_grid
);

   localparam int EXT_W = CFG_W + 1;

   logic [IDX_W-1:0] cols_ext;
   logic [IDX_W-1:0] offset;

   assign cols_ext = IDX_W'(size.cols);

   always_comb begin
      nbr_r   = cell_r;
      nbr_c   = cell_c;
      in_grid = 1'b0;
      offset  = '0;
      case (dir)
         DIR_UP: begin
            in_grid = (cell_r != '0);
            nbr_r   = cell_r - R_W'(1);
            offset  = IDX_W'(0) - cols_ext;
         end
         DIR_LEFT: begin
            in_grid = (cell_c != '0);
            nbr_c   = cell_c - C_W'(1);
            offset  = '1;
         end
         DIR_DOWN: begin
            in_grid = (EXT_W'(cell_r) + EXT_W'(1)) < EXT_W'(size.rows);
            nbr_r   = cell_r + R_W'(1);
            offset  = cols_ext;
         end
         DIR_RIGHT: begin
            in_grid = (EXT_W'(cell_c) + EXT_W'(1)) < EXT_W'(size.cols);
            nbr_c   = cell_c + C_W'(1);
            offset  = IDX_W'(1);
         end
         default: begin
            in_grid = 1'b0;
         end
      endcase
      // the shared adder
      nbr_idx = cell_idx + offset;
   end

endmodule

/* rtl/gbsp_csr.sv */
// ----------------------------------------------------------------------------
// gbsp_csr
// apb register file for grid size, with clamping to the supported range
// ----------------------------------------------------------------------------
module gbsp_csr import gbsp_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output gbsp_size_type         size
);

   logic [CFG_W-1:0]     rows_raw_ff, rows_raw_in;
   logic [CFG_W-1:0]     cols_raw_ff, cols_raw_in;
   logic [REG_SEL_W-1:0] reg_sel;
   logic                 wr_fire;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_LSB];
   assign wr_fire    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      rows_raw_in = rows_raw_ff;
      cols_raw_in = cols_raw_ff;
      if (wr_fire) begin
         case (reg_sel)
            REG_GRID_ROWS: rows_raw_in = csr_pwdata[CFG_W-1:0];
            REG_GRID_COLS: cols_raw_in = csr_pwdata[CFG_W-1:0];
            default: begin
               rows_raw_in = rows_raw_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_raw_ff <= RESET_ROWS;
         cols_raw_ff <= RESET_COLS;
      end else begin
         rows_raw_ff <= rows_raw_in;
         cols_raw_ff <= cols_raw_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GRID_ROWS: csr_prdata = CSR_DATA_W'(rows_raw_ff);
         REG_GRID_COLS: csr_prdata = CSR_DATA_W'(cols_raw_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // zero counts as one, anything above the build limit counts as the limit
   always_comb begin
      if (rows_raw_ff == '0) begin
         size.rows = CFG_W'(1);
      end else if (32'(rows_raw_ff) > MAX_ROWS) begin
         size.rows = CFG_W'(MAX_ROWS);
      end else begin
         size.rows = rows_raw_ff;
      end
      if (cols_raw_ff == '0) begin
         size.cols = CFG_W'(1);
      end else if (32'(cols_raw_ff) > MAX_COLS) begin
         size.cols = CFG_W'(MAX_COLS);
      end else begin
         size.cols = cols_raw_ff;
      end
   end

endmodule

/* rtl/grid_bfs_shortest_path.sv */
// ----------------------------------------------------------------------------
// grid_bfs_shortest_path
// loads a maze one cell per item, then runs a layered breadth-first search
// from the top-left cell and reports the path length to the bottom-right
//
//   channel  direction  handshake           payload
//   req      in         req_valid/ready     req_cell_open, req_last_cell
//   rsp      out        rsp_valid/ready     rsp_path_cells, rsp_reached
//   csr      in         apb psel/penable    grid_rows, grid_cols
//
// cell items fill the maze store in order; the item with last_cell set starts the search
// search: a sweep clears visited flags of cells not loaded, a start step
// queues the top-left cell, then each queued cell gets pop, fetch, four
// neighbor probes through the shared address unit, layer bookkeeping
// req_ready is low during the search and while a result waits on rsp
// reset is synchronous; the maze store holds no reset value
// ----------------------------------------------------------------------------
`include "grid_bfs_shortest_path_defines.svh"

module grid_bfs_shortest_path import gbsp_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cell_open,
   input  logic                  req_last_cell,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_path_cells,
   output logic                  rsp_reached,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int EFF_ROWS = (MAX_ROWS < 255) ? MAX_ROWS : 255;
   localparam int EFF_COLS = (MAX_COLS < 255) ? MAX_COLS : 255;
   localparam int DEPTH    = EFF_ROWS * EFF_COLS;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int PTR_W    = $clog2(DEPTH + 1);
   localparam int R_W      = $clog2(EFF_ROWS);
   localparam int C_W      = $clog2(EFF_COLS);
   localparam int QW       = IDX_W + R_W + C_W;
   localparam int PROD_W   = 2 * CFG_W;
   localparam int EXT_W    = CFG_W + 1;

   gbsp_size_type size;

   gbsp_csr #(
      .MAX_ROWS (EFF_ROWS),
      .MAX_COLS (EFF_COLS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .size        (size)
   );

   // registers
   gbsp_state_type   state_ff, state_in;
   logic [PTR_W-1:0] load_idx_ff, load_idx_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] layer_end_ff, layer_end_in;
   logic [CNT_W-1:0] layer_cnt_ff, layer_cnt_in;
   logic             found_ff, found_in;
   gbsp_dir_type     dir_ff, dir_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic [R_W-1:0]   ev_r_ff, ev_r_in;
   logic [C_W-1:0]   ev_c_ff, ev_c_in;
   logic [IDX_W-1:0] cell_idx_ff, cell_idx_in;
   logic [R_W-1:0]   cell_r_ff, cell_r_in;
   logic [C_W-1:0]   cell_c_ff, cell_c_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_path_ff, rsp_path_in;
   logic             rsp_reached_ff, rsp_reached_in;

   // memory ports
   logic             open_we;
   logic [IDX_W-1:0] open_waddr;
   logic             open_rd;
   logic             vis_we;
   logic [IDX_W-1:0] vis_waddr;
   logic             vis_wdata;
   logic             vis_rd;
   logic             q_we;
   logic [IDX_W-1:0] q_waddr;
   logic [QW-1:0]    q_wdata;
   logic [QW-1:0]    q_rd;

   // neighbor unit
   logic [IDX_W-1:0] nbr_idx;
   logic [R_W-1:0]   nbr_r;
   logic [C_W-1:0]   nbr_c;
   logic             nbr_in_grid;

   // misc
   logic [PTR_W-1:0] total;
   logic             req_fire;
   logic             load_wr;
   logic             push;
   logic [PTR_W-1:0] tail_next;
   logic             is_target;
   logic             found_now;
   logic             layer_left;
   logic             search_end;
   logic [CNT_W-1:0] layer_cnt_inc;

   assign total = PTR_W'(PROD_W'(size.rows) * PROD_W'(size.cols));

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign load_wr   = req_fire && (load_idx_ff < total);

   // a probe issued last cycle lands here
   assign push = ((state_ff == ST_PROBE) || (state_ff == ST_LAST)) && ev_valid_ff
                 && open_rd && !vis_rd;
   assign tail_next = tail_ff + PTR_W'(push);

   assign is_target = ((EXT_W'(cell_r_ff) + EXT_W'(1)) == EXT_W'(size.rows))
                   && ((EXT_W'(cell_c_ff) + EXT_W'(1)) == EXT_W'(size.cols));
   assign found_now     = found_ff || is_target;
   assign layer_left    = (head_ff != layer_end_ff);
   assign layer_cnt_inc = (layer_cnt_ff == CNT_MAX) ? layer_cnt_ff
                                                    : layer_cnt_ff + CNT_W'(1);
   assign search_end = (state_ff == ST_LAST) && !layer_left
                    && (found_now || (tail_next == head_ff));

   gbsp_nbr_unit #(
      .IDX_W (IDX_W),
      .R_W   (R_W),
      .C_W   (C_W)
   ) u_nbr (
      .dir      (dir_ff),
      .cell_idx (cell_idx_ff),
      .cell_r   (cell_r_ff),
      .cell_c   (cell_c_ff),
      .size     (size),
      .nbr_idx  (nbr_idx),
      .nbr_r    (nbr_r),
      .nbr_c    (nbr_c),
      .in_grid  (nbr_in_grid)
   );

   gbsp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_open_ram (
      .clock   (clock),
      .wr_en   (open_we),
      .wr_addr (open_waddr),
      .wr_data (req_cell_open),
      .rd_addr (nbr_idx),
      .rd_data (open_rd)
   );

   gbsp_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr (nbr_idx),
      .rd_data (vis_rd)
   );

   gbsp_ram #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (q_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_last_cell) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (load_idx_ff >= total) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_POP;
         ST_POP:   state_in = ST_FETCH;
         ST_FETCH: state_in = ST_PROBE;
         ST_PROBE: begin
            if (dir_ff == DIR_RIGHT) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (search_end) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_POP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      load_idx_in    = load_idx_ff;
      head_in        = head_ff;
      tail_in        = tail_next;
      layer_end_in   = layer_end_ff;
      layer_cnt_in   = layer_cnt_ff;
      found_in       = found_ff;
      dir_in         = dir_ff;
      ev_valid_in    = 1'b0;
      ev_idx_in      = nbr_idx;
      ev_r_in        = nbr_r;
      ev_c_in        = nbr_c;
      cell_idx_in    = cell_idx_ff;
      cell_r_in      = cell_r_ff;
      cell_c_in      = cell_c_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_path_in    = rsp_path_ff;
      rsp_reached_in = rsp_reached_ff;

      open_we    = load_wr;
      open_waddr = load_idx_ff[IDX_W-1:0];
      vis_we     = 1'b0;
      vis_waddr  = load_idx_ff[IDX_W-1:0];
      vis_wdata  = 1'b0;
      q_we       = push;
      q_waddr    = tail_ff[IDX_W-1:0];
      q_wdata    = {ev_idx_ff, ev_r_ff, ev_c_ff};

      if (push) begin
         vis_we    = 1'b1;
         vis_waddr = ev_idx_ff;
         vis_wdata = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            // loaded cells also get their visited flag cleared
            if (load_wr) begin
               vis_we      = 1'b1;
               load_idx_in = load_idx_ff + PTR_W'(1);
            end
         end
         ST_SWEEP: begin
            if (load_idx_ff < total) begin
               vis_we      = 1'b1;
               load_idx_in = load_idx_ff + PTR_W'(1);
            end else begin
               load_idx_in = '0;
            end
         end
         ST_START: begin
            // start cell is queued even when it is a wall
            vis_we       = 1'b1;
            vis_waddr    = '0;
            vis_wdata    = 1'b1;
            q_we         = 1'b1;
            q_waddr      = '0;
            q_wdata      = '0;
            head_in      = '0;
            tail_in      = PTR_W'(1);
            layer_end_in = PTR_W'(1);
            layer_cnt_in = '0;
            found_in     = 1'b0;
         end
         ST_POP: begin
            head_in = head_ff + PTR_W'(1);
         end
         ST_FETCH: begin
            cell_idx_in = q_rd[QW-1 -: IDX_W];
            cell_r_in   = q_rd[C_W +: R_W];
            cell_c_in   = q_rd[0 +: C_W];
            dir_in      = DIR_UP;
         end
         ST_PROBE: begin
            ev_valid_in = nbr_in_grid;
            case (dir_ff)
               DIR_UP:    dir_in = DIR_LEFT;
               DIR_LEFT:  dir_in = DIR_DOWN;
               DIR_DOWN:  dir_in = DIR_RIGHT;
               DIR_RIGHT: dir_in = DIR_UP;
               default:   dir_in = DIR_UP;
            endcase
         end
         ST_LAST: begin
            found_in = found_now;
            if (!layer_left) begin
               layer_cnt_in = layer_cnt_inc;
               layer_end_in = tail_next;
            end
            if (search_end) begin
               rsp_valid_in   = 1'b1;
               rsp_path_in    = layer_cnt_inc;
               rsp_reached_in = found_now;
            end
         end
         default: begin
            ev_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_idx_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         layer_end_ff <= '0;
         layer_cnt_ff <= '0;
         found_ff     <= 1'b0;
         dir_ff       <= DIR_UP;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_idx_ff  <= load_idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         layer_end_ff <= layer_end_in;
         layer_cnt_ff <= layer_cnt_in;
         found_ff     <= found_in;
         dir_ff       <= dir_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff      <= ev_idx_in;
      ev_r_ff        <= ev_r_in;
      ev_c_ff        <= ev_c_in;
      cell_idx_ff    <= cell_idx_in;
      cell_r_ff      <= cell_r_in;
      cell_c_ff      <= cell_c_in;
      rsp_path_ff    <= rsp_path_in;
      rsp_reached_ff <= rsp_reached_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_cells = rsp_path_ff;
   assign rsp_reached    = rsp_reached_ff;

   `GBSP_ASSERT_NOW(a_pop_has_entry, clock, reset, state_ff == ST_POP,
      head_ff < tail_ff, "queue popped while empty")
   `GBSP_ASSERT_NOW(a_tail_in_grid, clock, reset,
      (state_ff == ST_PROBE) || (state_ff == ST_LAST),
      tail_ff <= total, "queue holds more cells than the grid")
   `GBSP_ASSERT_NOW(a_rsp_from_search, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_LAST, "result raised outside search end")
   `GBSP_ASSERT_NEXT(a_done_blocks_input, clock, reset, search_end,
      rsp_valid_ff && !req_ready, "input taken while result pending")

endmodule
